// File: rtl/mhb_pkg.sv
// Shared types and codes for the multichannel history buffer.
// Command and result words, function and status codes; no dependencies.
package mhb_pkg;

  localparam int REC_W   = 64;
  localparam int CHAN_W  = 7;
  localparam int COUNT_W = 7;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 2;

  // function codes
  localparam logic FN_PUSH = 1'b0;
  localparam logic FN_SNAP = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_VALID    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_CHAN = 2'd2;

  typedef struct packed {
    logic               func;
    logic [CHAN_W-1:0]  channel;
    logic [REC_W-1:0]   record_in;
    logic [COUNT_W-1:0] request_count;
  } cmd_word_t;

  typedef struct packed {
    logic [REC_W-1:0]   record_out;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] item_total;
    logic [STAT_W-1:0]  status;
    logic               last;
  } res_word_t;

endpackage

// File: rtl/multichannel_history_buffer.sv
// Multichannel history buffer: a circular record history per channel.
// Command channel cmd (cmd_valid/cmd_ready) carries one word: func selects
// push (store record_in at the channel head) or snapshot (return the newest
// min(fill, request_count) records, oldest first). Result channel res
// (res_valid/res_ready) returns one word per record; last marks the final
// word of a run. An empty channel or zero request gives one word with status
// empty; an out-of-range channel gives one word with status bad channel on
// snapshot and is ignored on push.
// A push reads the channel state memory, then writes it back.
// A snapshot reads the state, then streams history reads at one
// record per cycle while res does not stall; the first word, like a
// status-only word, passes the read stage and the output register.
// The history read port sets this rate. The next command is taken once the
// last word of a run has left the read stage.
// Reset clears the per-channel valid bits at once: no clearing pass.
// When res stalls, reads pause with the record held in the read register
// and the output register; nothing is dropped.
module multichannel_history_buffer #(
  parameter int CHANNELS     = 100,
  parameter int DEPTH        = 64,
  parameter int RECORD_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  mhb_pkg::cmd_word_t cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output mhb_pkg::res_word_t res
);

  import mhb_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW   = $clog2(DEPTH);
  localparam int FW   = $clog2(DEPTH + 1);
  localparam int CW   = PW + FW;
  localparam int HAW  = $clog2(CHANNELS * DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_RUN  = 3'b100
  } state_t;

  state_t    state;
  state_t    state_next;
  cmd_word_t cur;

  // channel state memory signals
  logic              chan_rd_en;
  logic [CW-1:0]     chan_rd_data;
  logic              chan_wr_en;
  logic [CW-1:0]     chan_wr_data;
  logic [PW-1:0]     head;
  logic [FW-1:0]     fill;
  logic [PW-1:0]     head_next;
  logic [FW-1:0]     fill_next;

  // history memory signals
  logic                    hist_rd_en;
  logic [HAW-1:0]          hist_rd_addr;
  logic [RECORD_WIDTH-1:0] hist_rd_data;
  logic                    hist_wr_en;
  logic [HAW-1:0]          hist_wr_addr;

  // decode and run control
  logic               accept;
  logic               bad_chan;
  logic [CH_W-1:0]    ch_idx;
  logic [COUNT_W-1:0] items;
  logic [7:0]         start_sum;
  logic [PW-1:0]      start_idx;
  logic [PW-1:0]      run_idx;
  logic [COUNT_W-1:0] run_pos;
  logic [COUNT_W-1:0] run_total;
  logic               run_last;

  // read stage: word in flight towards the output register
  logic               pend;
  logic               pend_mem;
  logic [POS_W-1:0]   pend_pos;
  logic [COUNT_W-1:0] pend_total;
  logic [STAT_W-1:0]  pend_status;
  logic               pend_last;
  logic               pend_set_status;
  logic [STAT_W-1:0]  set_status;
  logic               load_now;
  logic               issue;

  assign cmd_ready = (state == S_IDLE) && !pend;
  assign accept    = cmd_valid && cmd_ready;
  assign bad_chan  = (32'(cur.channel) >= CHANNELS);
  assign ch_idx    = CH_W'(cur.channel);

  // channel state unpack and update
  assign head      = chan_rd_data[CW-1:FW];
  assign fill      = chan_rd_data[FW-1:0];
  assign head_next = (head == PW'(DEPTH - 1)) ? '0 : head + PW'(1);
  assign fill_next = (fill == FW'(DEPTH)) ? fill : fill + FW'(1);
  assign chan_rd_en = accept && (32'(cmd.channel) < CHANNELS);

  // run length and oldest index of the run
  always_comb begin
    if (COUNT_W'(fill) < cur.request_count) begin
      items = COUNT_W'(fill);
    end else begin
      items = cur.request_count;
    end
    start_sum = 8'(head) + 8'(DEPTH) - 8'(items);
    if (start_sum >= 8'(DEPTH)) begin
      start_sum = start_sum - 8'(DEPTH);
    end
    start_idx = PW'(start_sum);
  end

  // push write-back
  assign chan_wr_en   = (state == S_LOOK) && (cur.func == FN_PUSH) && !bad_chan;
  assign chan_wr_data = {head_next, fill_next};
  assign hist_wr_en   = chan_wr_en;
  assign hist_wr_addr = HAW'(ch_idx) * HAW'(DEPTH) + HAW'(head);

  // status-only results
  always_comb begin
    pend_set_status = 1'b0;
    set_status      = ST_EMPTY;
    if ((state == S_LOOK) && (cur.func == FN_SNAP)) begin
      if (bad_chan) begin
        pend_set_status = 1'b1;
        set_status      = ST_BAD_CHAN;
      end else if (items == '0) begin
        pend_set_status = 1'b1;
      end
    end
  end

  // history reads, one per free slot of the read stage
  assign load_now     = pend && (!res_valid || res_ready);
  assign issue        = (state == S_RUN) && (!pend || load_now);
  assign hist_rd_en   = issue;
  assign hist_rd_addr = HAW'(ch_idx) * HAW'(DEPTH) + HAW'(run_idx);
  assign run_last     = (run_pos + COUNT_W'(1) == run_total);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if ((cur.func == FN_SNAP) && !bad_chan && (items != '0)) begin
          state_next = S_RUN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RUN: begin
        if (issue && run_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the accepted command
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= cmd;
    end
  end

  // advance the run counters
  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      run_idx   <= start_idx;
      run_pos   <= '0;
      run_total <= items;
    end else if (issue) begin
      run_idx <= (run_idx == PW'(DEPTH - 1)) ? '0 : run_idx + PW'(1);
      run_pos <= run_pos + COUNT_W'(1);
    end
  end

  // read stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (issue || pend_set_status) begin
      pend <= 1'b1;
    end else if (load_now) begin
      pend <= 1'b0;
    end
  end

  // read stage tags
  always_ff @(posedge clk) begin
    if (issue) begin
      pend_mem    <= 1'b1;
      pend_pos    <= POS_W'(run_pos);
      pend_total  <= run_total;
      pend_status <= ST_VALID;
      pend_last   <= run_last;
    end else if (pend_set_status) begin
      pend_mem    <= 1'b0;
      pend_pos    <= '0;
      pend_total  <= '0;
      pend_status <= set_status;
      pend_last   <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_now) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_now) begin
      res.record_out <= pend_mem ? REC_W'(hist_rd_data) : '0;
      res.position   <= pend_pos;
      res.item_total <= pend_total;
      res.status     <= pend_status;
      res.last       <= pend_last;
    end
  end

  mhb_chan_mem #(
    .CHANNELS(CHANNELS),
    .WIDTH   (CW),
    .AW      (CH_W)
  ) u_chan_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (chan_rd_en),
    .rd_addr(CH_W'(cmd.channel)),
    .rd_data(chan_rd_data),
    .wr_en  (chan_wr_en),
    .wr_addr(ch_idx),
    .wr_data(chan_wr_data)
  );

  mhb_hist_mem #(
    .ENTRIES(CHANNELS * DEPTH),
    .WIDTH  (RECORD_WIDTH),
    .AW     (HAW)
  ) u_hist_mem (
    .clk    (clk),
    .rd_en  (hist_rd_en),
    .rd_addr(hist_rd_addr),
    .rd_data(hist_rd_data),
    .wr_en  (hist_wr_en),
    .wr_addr(hist_wr_addr),
    .wr_data(cur.record_in[RECORD_WIDTH-1:0])
  );

  // a run never reads past its length
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (run_pos < run_total))
    else $error("snapshot run counter beyond run length");

  // status words always close their run
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status != ST_VALID)) |-> res.last)
    else $error("status word without last");

  // record words carry a position inside the run
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status == ST_VALID)) |-> (7'(res.position) < res.item_total))
    else $error("record position outside run");

  // a loaded word shows on the result channel next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load_now |=> res_valid)
    else $error("loaded word not presented");

endmodule

// File: rtl/mhb_chan_mem.sv
// Per-channel head and fill memory, one word per channel, registered read.
// Valid bits in flip-flops make unwritten channels read as zero after reset.
module mhb_chan_mem #(
  parameter int CHANNELS = 100,
  parameter int WIDTH    = 13,
  parameter int AW       = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0]    mem [CHANNELS];
  logic [CHANNELS-1:0] valid;
  logic [WIDTH-1:0]    rd_word;
  logic                rd_valid;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // mark written channels, clear all on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // registered read, word and its valid bit held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word  <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_data = rd_valid ? rd_word : '0;

endmodule

// File: rtl/mhb_hist_mem.sv
// Record history memory for all channels, simple dual port.
// One write and one registered read per cycle; read data holds until next read.
module mhb_hist_mem #(
  parameter int ENTRIES = 6400,
  parameter int WIDTH   = 64,
  parameter int AW      = 13
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sim/history_checker.sv
// Checker for the multichannel history buffer: mirrors every channel's history,
// predicts the result words of each snapshot and compares them as they leave.
// Depends on mhb_pkg for the command and result word types and codes.
module history_checker
  import mhb_pkg::*;
#(
  parameter int CHANNELS     = 100,
  parameter int DEPTH        = 64,
  parameter int RECORD_WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  logic      cmd_ready,
  input  cmd_word_t cmd,
  input  logic      res_valid,
  input  logic      res_ready,
  input  res_word_t res,
  output int        error_count,
  output int        words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [REC_W-1:0] REC_MASK =
    (RECORD_WIDTH >= REC_W) ? '1 : ((64'd1 << RECORD_WIDTH) - 64'd1);

  // mirror of the per-channel histories
  logic [REC_W-1:0]   history [CHANNELS][DEPTH];
  logic [POS_W-1:0]   head    [CHANNELS];
  logic [COUNT_W-1:0] fill    [CHANNELS];

  // result words still owed by the block, oldest first
  res_word_t expected_words [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // store a record at the channel head; drop pushes to a bad channel
  task automatic store_record(input cmd_word_t w);
    int ch;
    ch = w.channel;
    if (ch >= CHANNELS) return;
    history[ch][head[ch]] = w.record_in & REC_MASK;
    head[ch] = (head[ch] == DEPTH - 1) ? '0 : head[ch] + 1'b1;
    if (fill[ch] < DEPTH) fill[ch] = fill[ch] + 1'b1;
  endtask

  // queue the words of one snapshot: newest records, oldest of them first
  task automatic predict_snapshot(input cmd_word_t w);
    int ch;
    int items;
    int start;
    res_word_t word;
    ch = w.channel;
    word = '0;
    word.last = 1'b1;
    if (ch >= CHANNELS) begin
      word.status = ST_BAD_CHAN;
      expected_words.push_back(word);
      return;
    end
    items = (fill[ch] < w.request_count) ? fill[ch] : w.request_count;
    if (items > DEPTH) items = DEPTH;
    if (items == 0) begin
      word.status = ST_EMPTY;
      expected_words.push_back(word);
      return;
    end
    start = (head[ch] + DEPTH - items) % DEPTH;
    for (int i = 0; i < items; i++) begin
      word.record_out = history[ch][(start + i) % DEPTH];
      word.position   = POS_W'(i);
      word.item_total = COUNT_W'(items);
      word.status     = ST_VALID;
      word.last       = (i == items - 1);
      expected_words.push_back(word);
    end
  endtask

  // track commands, then compare each accepted result word
  always @(posedge clk) begin
    res_word_t want;
    if (rst) begin
      expected_words.delete();
      foreach (head[i]) head[i] = '0;
      foreach (fill[i]) fill[i] = '0;
      error_count = 0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        if (cmd.func == FN_PUSH) store_record(cmd);
        else predict_snapshot(cmd);
      end
      if (res_valid && res_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", res));
        end else begin
          want = expected_words.pop_front();
          if (res.record_out !== want.record_out)
            report_mismatch($sformatf("record_out %h, want %h", res.record_out,
                                      want.record_out));
          if (res.position !== want.position)
            report_mismatch($sformatf("position %0d, want %0d", res.position,
                                      want.position));
          if (res.item_total !== want.item_total)
            report_mismatch($sformatf("item_total %0d, want %0d", res.item_total,
                                      want.item_total));
          if (res.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", res.status, want.status));
          if (res.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", res.last, want.last));
        end
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

// File: sim/multichannel_history_buffer_tb.sv
// Top of the multichannel history buffer testbench: clock, reset, command
// stimulus, result back-pressure, watchdog and verdict.
// Depends on mhb_pkg, the block and history_checker.
module multichannel_history_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mhb_pkg::*;

  localparam int CHANNELS     = 100;
  localparam int DEPTH        = 64;
  localparam int RECORD_WIDTH = 64;
  localparam int ITEM_TARGET  = 230;
  localparam int QUIET_FROM   = 190;
  localparam int DRAIN_EVERY  = 70;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 12;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      res_ready = 1'b0;
  cmd_word_t cmd       = '0;
  logic      cmd_ready;
  logic      res_valid;
  res_word_t res;
  int        error_count;
  int        words_pending;
  bit        quiet      = 1'b0;
  int        words_sent = 0;
  int        res_hold   = 0;

  multichannel_history_buffer #(
    .CHANNELS    (CHANNELS),
    .DEPTH       (DEPTH),
    .RECORD_WIDTH(RECORD_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  history_checker #(
    .CHANNELS    (CHANNELS),
    .DEPTH       (DEPTH),
    .RECORD_WIDTH(RECORD_WIDTH)
  ) hist_chk (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .error_count  (error_count),
    .words_pending(words_pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // stall the result side in random bursts; none once the run goes quiet
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (res_hold > 0) begin
      res_hold  <= res_hold - 1;
      res_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      res_hold  <= $urandom_range(0, 18);
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // end the run when nothing has moved for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [REC_W-1:0] rand_record();
    return {$urandom, $urandom};
  endfunction

  // favour a few channels so that their histories fill and wrap
  function automatic int busy_channel();
    case ($urandom_range(0, 5))
      0:       return CHANNELS - 1;
      1:       return $urandom_range(0, CHANNELS - 1);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  // offer one command word and hold it until taken, then maybe idle
  task automatic send_cmd(input logic fn, input int chan, input logic [REC_W-1:0] rec,
                          input int req);
    cmd_word_t w;
    w.func          = fn;
    w.channel       = chan[CHAN_W-1:0];
    w.record_in     = rec;
    w.request_count = req[COUNT_W-1:0];
    cmd       <= w;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    if (!(fn == FN_PUSH && chan >= CHANNELS)) words_sent++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // hold off commands until every owed result word has arrived
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int chan;
    int n;
    int next_drain;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty channel, zero request and bad channels before any push to a valid channel
    send_cmd(FN_SNAP, 0, '0, 5);
    send_cmd(FN_SNAP, 0, '1, 0);
    send_cmd(FN_SNAP, CHANNELS, '0, 1);
    send_cmd(FN_SNAP, 127, '1, 127);
    send_cmd(FN_PUSH, 127, '1, 127);
    send_cmd(FN_PUSH, CHANNELS, 64'h0123_4567_89ab_cdef, 3);
    // short history on the first channel
    send_cmd(FN_PUSH, 0, '0, 0);
    send_cmd(FN_PUSH, 0, '1, 127);
    send_cmd(FN_PUSH, 0, 64'ha5a5_5a5a_a5a5_5a5a, 64);
    send_cmd(FN_SNAP, 0, '0, 0);
    send_cmd(FN_SNAP, 0, '0, 1);
    send_cmd(FN_SNAP, 0, '0, 3);
    send_cmd(FN_SNAP, 0, '0, DEPTH);
    send_cmd(FN_SNAP, 0, '0, 127);
    // last channel, and the untouched channel 1
    send_cmd(FN_PUSH, CHANNELS - 1, 64'h8000_0000_0000_0001, 0);
    send_cmd(FN_PUSH, CHANNELS - 1, 64'h7fff_ffff_ffff_fffe, 0);
    send_cmd(FN_SNAP, CHANNELS - 1, '0, 2);
    send_cmd(FN_SNAP, CHANNELS - 1, '0, DEPTH);
    send_cmd(FN_SNAP, 1, '0, DEPTH);
    drain();

    // overfill one channel so the oldest records are overwritten
    chan = $urandom_range(4, CHANNELS - 2);
    repeat (DEPTH + $urandom_range(1, 8))
      send_cmd(FN_PUSH, chan, rand_record(), $urandom_range(0, 127));
    send_cmd(FN_SNAP, chan, rand_record(), DEPTH);
    send_cmd(FN_SNAP, chan, rand_record(), 3);

    // mostly push runs closed by a snapshot, with stray snapshots and noise
    next_drain = words_sent + DRAIN_EVERY;
    while (words_sent < ITEM_TARGET) begin
      if (words_sent >= QUIET_FROM && !quiet) quiet <= 1'b1;
      if (words_sent >= next_drain) begin
        drain();
        next_drain += DRAIN_EVERY;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          chan = busy_channel();
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
          repeat (n) send_cmd(FN_PUSH, chan, rand_record(), $urandom_range(0, 127));
          send_cmd(FN_SNAP, chan, rand_record(), $urandom_range(0, DEPTH));
        end
        6, 7: send_cmd(FN_SNAP, busy_channel(), rand_record(), $urandom_range(0, 127));
        default: send_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 127), rand_record(),
                          $urandom_range(0, 127));
      endcase
    end

    // wait out the last results and any push still in flight
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
